// File: hw/rtl/multi_channel_servo_pwm_core_macros.svh
// Assertion helpers for the servo PWM core.
`ifndef MULTI_CHANNEL_SERVO_PWM_CORE_MACROS_SVH
`define MULTI_CHANNEL_SERVO_PWM_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define MCSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define MCSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mcsp_pkg.sv
`default_nettype none

package mcsp_pkg;

  localparam int NumChannels = 6;
  localparam int ChanW       = 3;
  localparam int ActW        = 2;
  localparam int PulseW      = 16;
  localparam int AngleW      = 8;
  localparam int LevelsW     = 6;
  localparam int WidthW      = 12;
  localparam int CountW      = 16;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 16;

  localparam logic [WidthW-1:0] WidthMin    = 12'd500;
  localparam logic [WidthW-1:0] WidthMax    = 12'd2500;
  localparam logic [WidthW-1:0] CenterWidth = 12'd1500;
  localparam logic [AngleW-1:0] AngleMax    = 8'd180;
  localparam logic [PulseW-1:0] AngleBase   = 16'd1000;

  // angle * 1000 / 180 is computed as (angle * AngleRecip) >> AngleShift,
  // which is exact for every angle up to 180.
  localparam int AngleShift = 19;
  localparam int AngleProdW = 30;
  localparam logic [21:0] AngleRecip = 22'd2912750;

  localparam logic [CountW-1:0] PrescaleReset = 16'd71;
  localparam logic [CountW-1:0] PeriodReset   = 16'd19999;

  typedef enum logic [ActW-1:0] {
    ActTick     = 2'd0,
    ActSetUs    = 2'd1,
    ActSetAngle = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPrescale = 1'd0,
    CfgPeriod   = 1'd1
  } cfg_reg_e;

  function automatic logic [WidthW-1:0] clamp_width(input logic [PulseW-1:0] w);
    logic [WidthW-1:0] r;
    if (w < PulseW'(WidthMin)) begin
      r = WidthMin;
    end else if (w > PulseW'(WidthMax)) begin
      r = WidthMax;
    end else begin
      r = w[WidthW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mcsp_if.sv
`default_nettype none

interface mcsp_req_if import mcsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ActW-1:0]     action;
  logic [ChanW-1:0]    channel;
  logic [PulseW-1:0]   width_us;
  logic [AngleW-1:0]   angle_deg;

  modport source (output valid, action, channel, width_us, angle_deg, input ready);
  modport sink   (input valid, action, channel, width_us, angle_deg, output ready);
endinterface

interface mcsp_rsp_if import mcsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LevelsW-1:0]  pwm_levels;
  logic                frame_start;
  logic [WidthW-1:0]   applied_width;

  modport source (output valid, pwm_levels, frame_start, applied_width, input ready);
  modport sink   (input valid, pwm_levels, frame_start, applied_width, output ready);
endinterface

interface mcsp_cfg_if import mcsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/multi_channel_servo_pwm_core.sv
// Six-channel servo pulse generator.
// Requests arrive on req_i: a clock tick, a set-width command in microseconds,
// or a set-angle command. Every request yields exactly one response on rsp_o
// with the channel levels after that request, the frame wrap flag and the
// compare value that a set command wrote.
// A request is captured in an input register at the accepting edge and its
// response is loaded into the output register once that register is free,
// where rsp_o can take it. The counters and compare values update in that
// same step, so one request is taken every cycle while rsp_o does not stall.
// When rsp_o stalls, the response holds and the input register fills; req_i
// then drops ready until the response is taken.
// The cfg_i port writes the prescale divider (index 0) and the frame period
// (index 1); it is always ready and should be written only while idle.
// Reset empties both pipeline registers, clears both counters, sets every
// compare value to 1500 us, the divider to 71 and the period to 19999.
`default_nettype none

`include "multi_channel_servo_pwm_core_macros.svh"

module multi_channel_servo_pwm_core import mcsp_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  mcsp_req_if.sink   req_i,
  mcsp_rsp_if.source rsp_o,
  mcsp_cfg_if.sink   cfg_i
);

  logic [CountW-1:0] prescale_div_q;
  logic [CountW-1:0] period_len_q;
  logic [CountW-1:0] prescale_cnt_q, prescale_cnt_d;
  logic [CountW-1:0] frame_cnt_q, frame_cnt_d;
  logic [WidthW-1:0] compare_q [NumChannels];
  logic [WidthW-1:0] compare_d [NumChannels];

  logic              s1_valid_q;
  logic [ActW-1:0]   s1_action_q;
  logic [ChanW-1:0]  s1_channel_q;
  logic [PulseW-1:0] s1_pulse_q;
  logic [AngleW-1:0] s1_angle_q;

  logic               out_valid_q;
  logic [LevelsW-1:0] out_levels_q, out_levels_d;
  logic               out_wrap_q, out_wrap_d;
  logic [WidthW-1:0]  out_applied_q, out_applied_d;

  logic                  out_free;
  logic                  s1_adv;
  logic                  in_fire;
  logic [AngleW-1:0]     angle_clamped;
  logic [AngleProdW-1:0] angle_prod;
  logic [PulseW-1:0]     req_width;
  logic                  set_en;
  logic [WidthW-1:0]     set_width;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign in_fire     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign angle_clamped = (s1_angle_q > AngleMax) ? AngleMax : s1_angle_q;
  assign angle_prod    = AngleProdW'(angle_clamped) * AngleProdW'(AngleRecip);

  always_comb begin
    prescale_cnt_d = prescale_cnt_q;
    frame_cnt_d    = frame_cnt_q;
    out_wrap_d     = 1'b0;
    req_width      = s1_pulse_q;
    set_en         = 1'b0;
    case (s1_action_q)
      ActTick: begin
        if (prescale_cnt_q >= prescale_div_q) begin
          prescale_cnt_d = '0;
          if (frame_cnt_q >= period_len_q) begin
            frame_cnt_d = '0;
            out_wrap_d  = 1'b1;
          end else begin
            frame_cnt_d = frame_cnt_q + CountW'(1);
          end
        end else begin
          prescale_cnt_d = prescale_cnt_q + CountW'(1);
        end
      end
      ActSetUs: begin
        set_en = (32'(s1_channel_q) < NumChannels);
      end
      ActSetAngle: begin
        req_width = AngleBase + PulseW'(angle_prod[AngleProdW-1:AngleShift]);
        set_en    = (32'(s1_channel_q) < NumChannels);
      end
      default: begin
        set_en = 1'b0;
      end
    endcase
    set_width     = clamp_width(req_width);
    out_applied_d = set_en ? set_width : '0;
    for (int i = 0; i < NumChannels; i++) begin
      compare_d[i] = (set_en && s1_channel_q == ChanW'(i)) ? set_width : compare_q[i];
    end
    out_levels_d = '0;
    for (int i = 0; i < LevelsW; i++) begin
      if (i < NumChannels) begin
        out_levels_d[i] = frame_cnt_d < CountW'(compare_d[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_div_q <= PrescaleReset;
      period_len_q   <= PeriodReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgPrescale: prescale_div_q <= cfg_i.data;
        CfgPeriod:   period_len_q   <= cfg_i.data;
        default: begin
          prescale_div_q <= prescale_div_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_cnt_q <= '0;
      frame_cnt_q    <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        compare_q[i] <= CenterWidth;
      end
    end else if (s1_adv) begin
      prescale_cnt_q <= prescale_cnt_d;
      frame_cnt_q    <= frame_cnt_d;
      for (int i = 0; i < NumChannels; i++) begin
        compare_q[i] <= compare_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q  <= req_i.action;
      s1_channel_q <= req_i.channel;
      s1_pulse_q   <= req_i.width_us;
      s1_angle_q   <= req_i.angle_deg;
    end
    if (s1_adv) begin
      out_levels_q  <= out_levels_d;
      out_wrap_q    <= out_wrap_d;
      out_applied_q <= out_applied_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.pwm_levels    = out_levels_q;
  assign rsp_o.frame_start   = out_wrap_q;
  assign rsp_o.applied_width = out_applied_q;

  `MCSP_ASSERT_IMPL(a_wrap_all_high, out_valid_q && out_wrap_q, out_levels_q == {LevelsW{1'b1}}, "frame start without all channels high")
  `MCSP_ASSERT_IMPL(a_applied_range, out_valid_q && out_applied_q != '0, out_applied_q >= WidthMin && out_applied_q <= WidthMax, "applied width out of range")
  `MCSP_ASSERT_IMPL(a_ready_when_empty, !out_valid_q, req_i.ready, "input blocked while output register is empty")
  `MCSP_ASSERT_NEXT(a_s1_held, s1_valid_q && !out_free, s1_valid_q, "request lost while output stalled")

endmodule

`default_nettype wire
